// File: sv/cli_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the comparison line interpolator.
package cli_pkg;

    // Width of the resolution registers and of the configuration data port.
    localparam int RES_BITS = 13;
    // Width of the configuration register index.
    localparam int CFG_IDX_BITS = 2;

    localparam logic [RES_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
    localparam logic [RES_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // Walking direction class of a line.
    typedef enum logic [1:0] {
        QUAD_1 = 2'd0,
        QUAD_2 = 2'd1,
        QUAD_3 = 2'd2,
        QUAD_4 = 2'd3
    } quad_t;

endpackage

// File: sv/cli_setup.sv
`timescale 1ns / 1ps
// Line setup: deltas, step count and quadrant from the two end points.
module cli_setup #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] x0,
    input  logic [COORD_BITS-1:0] y0,
    input  logic [COORD_BITS-1:0] x1,
    input  logic [COORD_BITS-1:0] y1,
    output logic [COORD_BITS-1:0] dx,
    output logic [COORD_BITS-1:0] dy,
    output logic [COORD_BITS:0]   steps,
    output cli_pkg::quad_t        quad
);

    assign dx    = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
    assign dy    = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
    assign steps = {1'b0, dx} + {1'b0, dy};

    always_comb
    begin
        if (x1 > x0)
        begin
            quad = (y1 >= y0) ? cli_pkg::QUAD_1 : cli_pkg::QUAD_4;
        end
        else if (x1 < x0)
        begin
            // leftward horizontal line walks straight left
            quad = (y1 > y0) ? cli_pkg::QUAD_2 : cli_pkg::QUAD_3;
        end
        else
        begin
            // vertical line follows the sign of y
            quad = (y1 >= y0) ? cli_pkg::QUAD_2 : cli_pkg::QUAD_4;
        end
    end

endmodule

// File: sv/cli_walker.sv
`timescale 1ns / 1ps
// Line walker: holds the line state and advances one pixel per step.
module cli_walker #(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_en,
    input  logic                  step_en,
    input  logic [COORD_BITS-1:0] load_x,
    input  logic [COORD_BITS-1:0] load_y,
    input  logic [31:0]           load_color,
    input  logic [COORD_BITS-1:0] load_dx,
    input  logic [COORD_BITS-1:0] load_dy,
    input  logic [COORD_BITS:0]   load_steps,
    input  cli_pkg::quad_t        load_quad,
    output logic [COORD_BITS-1:0] cur_x,
    output logic [COORD_BITS-1:0] cur_y,
    output logic [31:0]           cur_color,
    output logic                  busy,
    output logic                  last
);

    localparam int ERR_BITS = COORD_BITS + 1;

    logic [COORD_BITS-1:0]      x_reg, x_next;
    logic [COORD_BITS-1:0]      y_reg, y_next;
    logic signed [ERR_BITS-1:0] err_reg, err_next;
    logic [COORD_BITS-1:0]      dx_reg, dx_next;
    logic [COORD_BITS-1:0]      dy_reg, dy_next;
    logic [COORD_BITS:0]        steps_reg, steps_next;
    cli_pkg::quad_t             quad_reg, quad_next;
    logic [31:0]                color_reg, color_next;

    logic signed [ERR_BITS-1:0] dx_ext;
    logic signed [ERR_BITS-1:0] dy_ext;

    assign dx_ext = signed'({1'b0, dx_reg});
    assign dy_ext = signed'({1'b0, dy_reg});

    assign busy      = (steps_reg != '0);
    assign last      = (steps_reg == {{COORD_BITS{1'b0}}, 1'b1});
    assign cur_x     = x_reg;
    assign cur_y     = y_reg;
    assign cur_color = color_reg;

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        err_next   = err_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        steps_next = steps_reg;
        quad_next  = quad_reg;
        color_next = color_reg;
        if (load_en)
        begin
            // restart, even over a line in progress
            x_next     = load_x;
            y_next     = load_y;
            err_next   = '0;
            dx_next    = load_dx;
            dy_next    = load_dy;
            steps_next = load_steps;
            quad_next  = load_quad;
            color_next = load_color;
        end
        else if (step_en && busy)
        begin
            steps_next = steps_reg - 1'b1;
            if (!err_reg[ERR_BITS-1])
            begin
                case (quad_reg)
                    cli_pkg::QUAD_1:
                    begin
                        x_next   = x_reg + 1'b1;
                        err_next = err_reg - dy_ext;
                    end
                    cli_pkg::QUAD_2:
                    begin
                        y_next   = y_reg + 1'b1;
                        err_next = err_reg - dx_ext;
                    end
                    cli_pkg::QUAD_3:
                    begin
                        x_next   = x_reg - 1'b1;
                        err_next = err_reg - dy_ext;
                    end
                    default:
                    begin
                        y_next   = y_reg - 1'b1;
                        err_next = err_reg - dx_ext;
                    end
                endcase
            end
            else
            begin
                case (quad_reg)
                    cli_pkg::QUAD_1:
                    begin
                        y_next   = y_reg + 1'b1;
                        err_next = err_reg + dx_ext;
                    end
                    cli_pkg::QUAD_2:
                    begin
                        x_next   = x_reg - 1'b1;
                        err_next = err_reg + dy_ext;
                    end
                    cli_pkg::QUAD_3:
                    begin
                        y_next   = y_reg - 1'b1;
                        err_next = err_reg + dx_ext;
                    end
                    default:
                    begin
                        x_next   = x_reg + 1'b1;
                        err_next = err_reg + dy_ext;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            err_reg   <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            steps_reg <= '0;
            quad_reg  <= cli_pkg::QUAD_1;
            color_reg <= '0;
        end
        else
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            err_reg   <= err_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            steps_reg <= steps_next;
            quad_reg  <= quad_next;
            color_reg <= color_next;
        end
    end

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !load_en && last |=> !busy)
        else $error("line did not end after its last pixel");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !load_en && !busy |=> !busy)
        else $error("walker became busy without a load");

    a_step_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !load_en && busy |=> steps_reg == $past(steps_reg) - 1'b1)
        else $error("step count did not advance by one");

endmodule

// File: sv/comparison_line_interpolator.sv
`timescale 1ns / 1ps
// A step request's pixel is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while the output register is empty or being taken (out_ready).
// Load requests and steps on an idle line produce no pixel.
// Reset (rst_n, async, low) clears the line state and empties the output register;
// screen size returns to 1024 x 768.
module comparison_line_interpolator #(
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cli_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [cli_pkg::RES_BITS-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [COORD_BITS-1:0]         start_x,
    input  logic [COORD_BITS-1:0]         start_y,
    input  logic [COORD_BITS-1:0]         end_x,
    input  logic [COORD_BITS-1:0]         end_y,
    input  logic [31:0]                   line_color,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COORD_BITS-1:0]         pixel_x,
    output logic [COORD_BITS-1:0]         pixel_y,
    output logic [31:0]                   pixel_color,
    output logic                          on_screen,
    output logic                          last_pixel
);

    localparam int CMP_W = (COORD_BITS > cli_pkg::RES_BITS) ? COORD_BITS : cli_pkg::RES_BITS;

    logic [cli_pkg::RES_BITS-1:0] width_reg;
    logic [cli_pkg::RES_BITS-1:0] height_reg;

    logic                  in_fire;
    logic                  load_en;
    logic                  step_en;
    logic                  emit;
    logic [COORD_BITS-1:0] s_dx;
    logic [COORD_BITS-1:0] s_dy;
    logic [COORD_BITS:0]   s_steps;
    cli_pkg::quad_t        s_quad;
    logic [COORD_BITS-1:0] w_x;
    logic [COORD_BITS-1:0] w_y;
    logic [31:0]           w_color;
    logic                  w_busy;
    logic                  w_last;
    logic                  w_on_screen;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] py_reg;
    logic [31:0]           pcolor_reg;
    logic                  onscr_reg;
    logic                  plast_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign load_en  = in_fire && (mode == cli_pkg::MODE_LOAD);
    assign step_en  = in_fire && (mode == cli_pkg::MODE_STEP);
    assign emit     = step_en && w_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cli_pkg::SCREEN_WIDTH_RESET;
            height_reg <= cli_pkg::SCREEN_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cli_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                cli_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cli_setup #(
        .COORD_BITS(COORD_BITS)
    ) u_setup (
        .x0    (start_x),
        .y0    (start_y),
        .x1    (end_x),
        .y1    (end_y),
        .dx    (s_dx),
        .dy    (s_dy),
        .steps (s_steps),
        .quad  (s_quad)
    );

    cli_walker #(
        .COORD_BITS(COORD_BITS)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (load_en),
        .step_en    (step_en),
        .load_x     (start_x),
        .load_y     (start_y),
        .load_color (line_color),
        .load_dx    (s_dx),
        .load_dy    (s_dy),
        .load_steps (s_steps),
        .load_quad  (s_quad),
        .cur_x      (w_x),
        .cur_y      (w_y),
        .cur_color  (w_color),
        .busy       (w_busy),
        .last       (w_last)
    );

    assign w_on_screen = (CMP_W'(w_x) < CMP_W'(width_reg))
                      && (CMP_W'(w_y) < CMP_W'(height_reg));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the pixel as it stands before the step moves it
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            px_reg     <= w_x;
            py_reg     <= w_y;
            pcolor_reg <= w_color;
            onscr_reg  <= w_on_screen;
            plast_reg  <= w_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pcolor_reg;
    assign on_screen   = onscr_reg;
    assign last_pixel  = plast_reg;

    a_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && w_busy |=> out_valid)
        else $error("busy step request gave no pixel");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        load_en && !out_valid_reg |=> !out_valid)
        else $error("load request produced a pixel");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !in_fire |=> !out_valid)
        else $error("taken pixel was repeated");

endmodule

// File: dv/tb_comparison_line_interpolator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the comparison line interpolator: pixel scoreboard, drivers, run plan.
module tb_comparison_line_interpolator;

    localparam int COORD_BITS    = 12;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PRINT_CAP     = 40;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [31:0]           color;
        logic                  on_screen;
        logic                  last;
    } pixel_t;

    class pixel_scoreboard;
        logic [COORD_BITS-1:0]        cur_x;
        logic [COORD_BITS-1:0]        cur_y;
        logic [COORD_BITS-1:0]        span_x;
        logic [COORD_BITS-1:0]        span_y;
        logic signed [COORD_BITS:0]   err;
        logic [COORD_BITS:0]          steps_left;
        cli_pkg::quad_t               quad;
        logic [31:0]                  color;
        bit                           busy;
        logic [cli_pkg::RES_BITS-1:0] width;
        logic [cli_pkg::RES_BITS-1:0] height;
        pixel_t                       expected_pixels[$];
        int                           mismatches;
        int                           pixels_checked;
        int                           loads;

        function new();
            cur_x = '0;
            cur_y = '0;
            span_x = '0;
            span_y = '0;
            err = '0;
            steps_left = '0;
            quad = cli_pkg::QUAD_1;
            color = '0;
            busy = 1'b0;
            width = cli_pkg::SCREEN_WIDTH_RESET;
            height = cli_pkg::SCREEN_HEIGHT_RESET;
            mismatches = 0;
            pixels_checked = 0;
            loads = 0;
        endfunction

        // Advance the line walker for one accepted request; queue the pixel it emits.
        function void note_request(logic m, logic [COORD_BITS-1:0] x0, logic [COORD_BITS-1:0] y0,
                                   logic [COORD_BITS-1:0] x1, logic [COORD_BITS-1:0] y1,
                                   logic [31:0] c);
            pixel_t px;
            logic signed [COORD_BITS:0] dx_s;
            logic signed [COORD_BITS:0] dy_s;
            if (m == cli_pkg::MODE_LOAD) begin
                span_x = (x1 >= x0) ? x1 - x0 : x0 - x1;
                span_y = (y1 >= y0) ? y1 - y0 : y0 - y1;
                steps_left = {1'b0, span_x} + {1'b0, span_y};
                if (x1 > x0)
                    quad = (y1 >= y0) ? cli_pkg::QUAD_1 : cli_pkg::QUAD_4;
                else if (x1 < x0)
                    quad = (y1 > y0) ? cli_pkg::QUAD_2 : cli_pkg::QUAD_3;
                else
                    quad = (y1 >= y0) ? cli_pkg::QUAD_2 : cli_pkg::QUAD_4;
                cur_x = x0;
                cur_y = y0;
                err = '0;
                color = c;
                busy = (steps_left != 0);
                loads++;
                return;
            end
            if (!busy)
                return;
            px.x = cur_x;
            px.y = cur_y;
            px.color = color;
            px.on_screen = ({1'b0, cur_x} < width) && ({1'b0, cur_y} < height);
            px.last = (steps_left == 1);
            expected_pixels.push_back(px);
            dx_s = $signed({1'b0, span_x});
            dy_s = $signed({1'b0, span_y});
            if (err >= 0) begin
                case (quad)
                    cli_pkg::QUAD_1: begin cur_x = cur_x + 1'b1; err = err - dy_s; end
                    cli_pkg::QUAD_2: begin cur_y = cur_y + 1'b1; err = err - dx_s; end
                    cli_pkg::QUAD_3: begin cur_x = cur_x - 1'b1; err = err - dy_s; end
                    default: begin cur_y = cur_y - 1'b1; err = err - dx_s; end
                endcase
            end
            else begin
                case (quad)
                    cli_pkg::QUAD_1: begin cur_y = cur_y + 1'b1; err = err + dx_s; end
                    cli_pkg::QUAD_2: begin cur_x = cur_x - 1'b1; err = err + dy_s; end
                    cli_pkg::QUAD_3: begin cur_y = cur_y - 1'b1; err = err + dx_s; end
                    default: begin cur_x = cur_x + 1'b1; err = err + dy_s; end
                endcase
            end
            steps_left = steps_left - 1'b1;
            busy = (steps_left != 0);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel (%0d,%0d) with no request waiting", got.x, got.y));
                return;
            end
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (got.x !== want.x)
                report_mismatch($sformatf("pixel_x %0d, want %0d", got.x, want.x));
            if (got.y !== want.y)
                report_mismatch($sformatf("pixel_y %0d, want %0d", got.y, want.y));
            if (got.color !== want.color)
                report_mismatch($sformatf("pixel_color %h, want %h", got.color, want.color));
            if (got.on_screen !== want.on_screen)
                report_mismatch($sformatf("on_screen %b, want %b at (%0d,%0d)",
                                          got.on_screen, want.on_screen, want.x, want.y));
            if (got.last !== want.last)
                report_mismatch($sformatf("last_pixel %b, want %b at (%0d,%0d)",
                                          got.last, want.last, want.x, want.y));
        endtask
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [cli_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [cli_pkg::RES_BITS-1:0]     cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic                             mode;
    logic [COORD_BITS-1:0]            start_x;
    logic [COORD_BITS-1:0]            start_y;
    logic [COORD_BITS-1:0]            end_x;
    logic [COORD_BITS-1:0]            end_y;
    logic [31:0]                      line_color;
    logic                             out_valid;
    logic                             out_ready;
    logic [COORD_BITS-1:0]            pixel_x;
    logic [COORD_BITS-1:0]            pixel_y;
    logic [31:0]                      pixel_color;
    logic                             on_screen;
    logic                             last_pixel;

    pixel_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int settings_used;

    comparison_line_interpolator #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .line_color (line_color),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_color(pixel_color),
        .on_screen  (on_screen),
        .last_pixel (last_pixel)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Check accepted pixels and drive the receiver's stalls.
    always @(posedge clk)
    begin : pixel_monitor
        pixel_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.x = pixel_x;
            got.y = pixel_y;
            got.color = pixel_color;
            got.on_screen = on_screen;
            got.last = last_pixel;
            sb.check_pixel(got);
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int line_length(int x0, int y0, int x1, int y1);
        return ((x1 >= x0) ? x1 - x0 : x0 - x1) + ((y1 >= y0) ? y1 - y0 : y0 - y1);
    endfunction

    // Present one request, hold it until accepted, then hand it to the scoreboard.
    task automatic send_request(logic m, logic [COORD_BITS-1:0] x0, logic [COORD_BITS-1:0] y0,
                                logic [COORD_BITS-1:0] x1, logic [COORD_BITS-1:0] y1,
                                logic [31:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        start_x <= x0;
        start_y <= y0;
        end_x <= x1;
        end_y <= y1;
        line_color <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(m, x0, y0, x1, y1, c);
    endtask

    // Step requests carry random coordinates and colour, which the block must ignore.
    task automatic send_step();
        send_request(cli_pkg::MODE_STEP,
                     COORD_BITS'($urandom_range(COORD_MAX)), COORD_BITS'($urandom_range(COORD_MAX)),
                     COORD_BITS'($urandom_range(COORD_MAX)), COORD_BITS'($urandom_range(COORD_MAX)),
                     $urandom());
    endtask

    task automatic send_line(int x0, int y0, int x1, int y1, logic [31:0] c, int n_steps);
        send_request(cli_pkg::MODE_LOAD, COORD_BITS'(x0), COORD_BITS'(y0),
                     COORD_BITS'(x1), COORD_BITS'(y1), c);
        repeat (n_steps)
            send_step();
    endtask

    // Drop valid, drain every expected pixel and let the block go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_screen(logic [cli_pkg::RES_BITS-1:0] w, logic [cli_pkg::RES_BITS-1:0] h);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= cli_pkg::REG_SCREEN_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        sb.width = w;
        cfg_index <= cli_pkg::REG_SCREEN_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        sb.height = h;
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly complete short lines; some long lines cut short by a reload, some overrun steps.
    task automatic run_lines(int n_items);
        int sent;
        int pick;
        int x0;
        int y0;
        int x1;
        int y1;
        int len;
        int n;
        int span;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if ($urandom_range(2) == 0)
                begin
                    x0 = clamp_coord(int'(sb.width) - int'($urandom_range(6)));
                    y0 = clamp_coord(int'(sb.height) - int'($urandom_range(6)));
                end
                else
                begin
                    x0 = $urandom_range(COORD_MAX);
                    y0 = $urandom_range(COORD_MAX);
                end
                x1 = clamp_coord(x0 + int'($urandom_range(24)) - 12);
                y1 = clamp_coord(y0 + int'($urandom_range(24)) - 12);
            end
            else if (pick < 85)
            begin
                case ($urandom_range(2))
                    0: x0 = 0;
                    1: x0 = COORD_MAX;
                    default: x0 = $urandom_range(COORD_MAX);
                endcase
                y0 = ($urandom_range(1) == 0) ? $urandom_range(COORD_MAX) : COORD_MAX;
                span = $urandom_range(10);
                if ($urandom_range(1) == 0) span = -span;
                x1 = x0;
                y1 = y0;
                if ($urandom_range(1) == 0)
                    x1 = clamp_coord(x0 + span);
                else
                    y1 = clamp_coord(y0 + span);
            end
            else
            begin
                x0 = $urandom_range(COORD_MAX);
                y0 = $urandom_range(COORD_MAX);
                x1 = $urandom_range(COORD_MAX);
                y1 = $urandom_range(COORD_MAX);
            end
            len = line_length(x0, y0, x1, y1);
            if (pick >= 85)
                n = $urandom_range(30, 1);
            else if ($urandom_range(9) == 0)
                n = $urandom_range(len);
            else
                n = len + (($urandom_range(3) == 0) ? 1 : 0);
            send_line(x0, y0, x1, y1, $urandom(), n);
            sent += 1 + ((n < len) ? n : len);
        end
    endtask

    task automatic run_phase(logic [cli_pkg::RES_BITS-1:0] w, logic [cli_pkg::RES_BITS-1:0] h,
                             int send_pct, int stall_pct, int n_items);
        write_screen(w, h);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        run_lines(n_items);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= cli_pkg::REG_SCREEN_WIDTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        mode <= cli_pkg::MODE_LOAD;
        start_x <= '0;
        start_y <= '0;
        end_x <= '0;
        end_y <= '0;
        line_color <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        settings_used = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle step, zero-length line, every quadrant, both axis directions,
        // coordinate extremes, reload mid-line and the reset screen edge.
        send_step();
        send_line(5, 5, 5, 5, 32'h0000_0000, 1);
        send_line(0, 0, 2, 1, 32'hFFFF_FFFF, 3);
        send_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX, 32'hA5A5_5A5A, 2);
        send_line(10, 0, 10, 2, 32'h5A5A_A5A5, 2);
        send_line(10, COORD_MAX, 10, COORD_MAX - 2, 32'h0123_4567, 2);
        send_line(COORD_MAX, 0, COORD_MAX - 1, 1, 32'h89AB_CDEF, 2);
        send_line(0, COORD_MAX, 1, COORD_MAX - 1, 32'hFEDC_BA98, 2);
        send_line(0, 0, COORD_MAX, COORD_MAX, 32'h0000_0001, 1);
        send_line(1023, 767, 1024, 768, 32'h8000_0000, 3);

        run_phase(13'd1024, 13'd768, 0, 0, 80);
        run_phase(13'd0, 13'd0, 85, 0, 80);
        run_phase(13'd8191, 13'd8191, 0, 85, 80);
        run_phase(13'd1, 13'd1, 29, 29, 80);
        run_phase(13'd4096, 13'd4096, 0, 0, 80);
        run_phase(13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)), 85, 0, 80);
        run_phase(13'd4095, 13'd1, 0, 85, 80);
        run_phase(13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)), 29, 29, 80);

        settle();
        repeat (8)
            @(posedge clk);
        $display("run covered %0d line loads and %0d checked pixels over %0d screen settings",
                 sb.loads, sb.pixels_checked, settings_used);
        $display("handshake mixes: free, sender idle 85%%, receiver stall 85%%, both 29%%");
        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches, %0d pixels outstanding",
                     sb.mismatches, sb.expected_pixels.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
